// File: src/kaa_pkg.sv
// Package: shared types, constants and helpers of the k-means assignment block.
package kaa_pkg;
	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS = 16;
	localparam int COORD_WIDTH = 16;
	localparam int CL_W = $clog2(MAX_CLUSTERS);
	localparam int DIM_W = $clog2(MAX_DIMS);
	localparam int CFG_W = 5;
	localparam int PART_W = 37;
	localparam int DIST_W = 36;
	localparam int SUM_W = 48;
	localparam int CNT_W = 32;
	localparam int DIFF_W = COORD_WIDTH + 1;
	localparam int SQ_W = 2 * DIFF_W;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_DATA = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ = 2'd3
	} req_t;

	typedef enum logic {
		RES_MEMBER = 1'b0,
		RES_READ = 1'b1
	} res_kind_t;

	typedef enum logic [0:0] {
		CFG_CLUSTERS = 1'b0,
		CFG_DIMS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_PICK,
		ST_SUMRD,
		ST_SUMWR,
		ST_CLEAR,
		ST_READ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [CL_W:0] nk;
		logic [DIM_W:0] nd;
	} eff_cfg_t;

	// Clamp a register to 1..max.
	function automatic logic [8:0] eff_val(input logic [CFG_W-1:0] raw, input int maxv);
		logic [8:0] r;
		r = 9'(raw);
		if (r == 9'd0) r = 9'd1;
		else if (r > 9'(maxv)) r = 9'(maxv);
		return r;
	endfunction
endpackage

// File: src/kaa_if.sv
// Interfaces: valid/ready channels for request and result items.
interface kaa_req_if;
	import kaa_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [3:0] cluster_sel;
	logic [3:0] dim_sel;
	logic signed [COORD_WIDTH-1:0] coord;
	modport source(output valid, req_type, cluster_sel, dim_sel, coord, input ready);
	modport sink(input valid, req_type, cluster_sel, dim_sel, coord, output ready);
endinterface

interface kaa_res_if;
	import kaa_pkg::*;
	logic valid;
	logic ready;
	logic result_kind;
	logic [3:0] assigned_cluster;
	logic [DIST_W-1:0] min_distance;
	logic signed [SUM_W-1:0] cluster_sum;
	logic [CNT_W-1:0] cluster_count;
	modport source(output valid, result_kind, assigned_cluster, min_distance, cluster_sum,
		cluster_count, input ready);
	modport sink(input valid, result_kind, assigned_cluster, min_distance, cluster_sum,
		cluster_count, output ready);
endinterface

// File: src/kmeans_assign_accumulate.sv
// Top level: k-means assignment with per-cluster saturating accumulators.
//  channel | dir | handshake      | payload
//  req     | in  | valid/ready    | req_type, cluster_sel, dim_sel, coord
//  res     | out | valid/ready    | result_kind, assigned_cluster, min_distance, sum, count
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
// A data coordinate steps through the clusters in use, reading each centroid and then
// updating that cluster's partial; a vector's last coordinate adds a minimum search over
// them, a sum read-modify-write per dimension in use and a load of the result register.
// A read passes through the read and output states after its accept. A clear sweeps all
// MAX_CLUSTERS*MAX_DIMS sum entries, one per cycle. Reset clears control, partials and
// counts and sets both config registers to 2; sums are cleared by a sweep after reset
// (no item accepted meanwhile). A stalled result holds the block.
module kmeans_assign_accumulate
	import kaa_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	kaa_req_if.sink req,
	kaa_res_if.source res
);
	localparam int SADDR_W = CL_W + DIM_W;

	logic [CFG_W-1:0] nk_raw_q, nd_raw_q;
	eff_cfg_t cfg;
	state_t state_q, state_d;

	// latched item
	logic [1:0] rtype_q;
	logic [CL_W-1:0] csel_q;
	logic [DIM_W-1:0] dsel_q;
	logic sel_ok_q;
	logic signed [COORD_WIDTH-1:0] cv_q;
	logic last_q;

	logic [CL_W:0] ci_q;
	logic [DIM_W:0] di_q;
	logic [SADDR_W:0] clr_q;
	logic phase_q;
	logic [CL_W-1:0] best_q;
	logic [PART_W-1:0] bestd_q;

	logic [PART_W-1:0] part_q [MAX_CLUSTERS];
	logic signed [COORD_WIDTH-1:0] vbuf_q [MAX_DIMS];
	logic [CNT_W-1:0] cnt_q [MAX_CLUSTERS];

	// result register
	logic res_v_q;
	logic res_kind_q;
	logic [3:0] res_cl_q;
	logic [DIST_W-1:0] res_dist_q;
	logic [SUM_W-1:0] res_sum_q;
	logic [CNT_W-1:0] res_cnt_q;

	// memories
	logic cen_we;
	logic [SADDR_W-1:0] cen_waddr, cen_raddr;
	logic [COORD_WIDTH-1:0] cen_rdata;
	logic sum_we;
	logic [SADDR_W-1:0] sum_waddr, sum_raddr;
	logic [SUM_W-1:0] sum_wdata, sum_rdata;

	always_comb begin
		cfg.nk = (CL_W+1)'(eff_val(nk_raw_q, MAX_CLUSTERS));
		cfg.nd = (DIM_W+1)'(eff_val(nd_raw_q, MAX_DIMS));
	end

	kaa_ram #(.WIDTH(COORD_WIDTH), .DEPTH(MAX_CLUSTERS*MAX_DIMS)) u_cen (
		.clk, .we(cen_we), .waddr(cen_waddr), .wdata(req.coord),
		.raddr(cen_raddr), .rdata(cen_rdata));

	kaa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CLUSTERS*MAX_DIMS)) u_sum (
		.clk, .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata));

	logic acc;
	assign req.ready = (state_q == ST_IDLE) && !res_v_q;
	assign acc = req.valid && req.ready;
	assign cen_we = acc && (req.req_type == REQ_LOAD) && (32'(req.cluster_sel) < MAX_CLUSTERS)
		&& (32'(req.dim_sel) < MAX_DIMS);
	assign cen_waddr = {CL_W'(req.cluster_sel), DIM_W'(req.dim_sel)};
	assign cen_raddr = {ci_q[CL_W-1:0], dsel_q};

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b);
		logic signed [SUM_W:0] s;
		s = $signed({a[SUM_W-1], a}) + (SUM_W+1)'(b);
		if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
			: {1'b0, {(SUM_W-1){1'b1}}};
		return s[SUM_W-1:0];
	endfunction

	// sum memory addressing
	always_comb begin
		sum_raddr = (state_q == ST_READ) ? {csel_q, dsel_q} : {best_q, di_q[DIM_W-1:0]};
		sum_we = 1'b0;
		sum_waddr = {best_q, di_q[DIM_W-1:0]};
		sum_wdata = '0;
		if (state_q == ST_CLEAR) begin
			sum_we = 1'b1;
			sum_waddr = clr_q[SADDR_W-1:0];
		end else if (state_q == ST_SUMWR) begin
			sum_we = 1'b1;
			sum_wdata = sat_add(sum_rdata, vbuf_q[di_q[DIM_W-1:0]]);
		end
	end

	// squared difference and saturating partial update
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0] adiff;
	logic [SQ_W-1:0] sq;
	logic [PART_W:0] psum;
	logic [PART_W-1:0] pnew;
	always_comb begin
		diff = DIFF_W'(cv_q) - DIFF_W'($signed(cen_rdata));
		adiff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		sq = SQ_W'(adiff) * SQ_W'(adiff);
		psum = (PART_W+1)'(part_q[ci_q[CL_W-1:0]]) + (PART_W+1)'(sq);
		pnew = psum[PART_W] ? {PART_W{1'b1}} : psum[PART_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) begin
				case (req_t'(req.req_type))
					REQ_DATA: if (5'(req.dim_sel) < 5'(cfg.nd)) state_d = ST_DIST;
					REQ_CLEAR: state_d = ST_CLEAR;
					REQ_READ: state_d = ST_READ;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_DIST: if (phase_q && ci_q + 1'b1 == cfg.nk)
				state_d = last_q ? ST_PICK : ST_IDLE;
			ST_PICK: if (ci_q + 1'b1 >= cfg.nk) state_d = ST_SUMRD;
			ST_SUMRD: state_d = ST_SUMWR;
			ST_SUMWR: state_d = (di_q + 1'b1 == cfg.nd) ? ST_OUT : ST_SUMRD;
			ST_CLEAR: if (clr_q == (SADDR_W+1)'(MAX_CLUSTERS*MAX_DIMS-1)) state_d = ST_IDLE;
			ST_READ: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nk_raw_q <= CFG_W'(2);
			nd_raw_q <= CFG_W'(2);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CLUSTERS: nk_raw_q <= cfg_data;
				CFG_DIMS: nd_raw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q <= '0;
			di_q <= '0;
			clr_q <= '0;
			phase_q <= 1'b0;
			res_v_q <= 1'b0;
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				part_q[i] <= '0;
				cnt_q[i] <= '0;
			end
		end else begin
			if (res_v_q && res.ready) res_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (acc) begin
					ci_q <= '0;
					di_q <= '0;
					clr_q <= '0;
					phase_q <= 1'b0;
				end
				ST_DIST: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						part_q[ci_q[CL_W-1:0]] <= pnew;
						ci_q <= (ci_q + 1'b1 == cfg.nk) ? '0 : ci_q + 1'b1;
					end
				end
				ST_PICK: ci_q <= ci_q + 1'b1;
				ST_SUMWR: di_q <= di_q + 1'b1;
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					for (int i = 0; i < MAX_CLUSTERS; i++) cnt_q[i] <= '0;
				end
				ST_OUT: begin
					res_v_q <= 1'b1;
					if (rtype_q == REQ_DATA) begin
						for (int i = 0; i < MAX_CLUSTERS; i++) part_q[i] <= '0;
						if (cnt_q[best_q] != {CNT_W{1'b1}}) cnt_q[best_q] <= cnt_q[best_q] + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// item latch, vector buffer, minimum search, result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rtype_q <= req.req_type;
			csel_q <= CL_W'(req.cluster_sel);
			dsel_q <= DIM_W'(req.dim_sel);
			sel_ok_q <= (32'(req.cluster_sel) < MAX_CLUSTERS) && (32'(req.dim_sel) < MAX_DIMS);
			cv_q <= req.coord;
			last_q <= (5'(req.dim_sel) == 5'(cfg.nd) - 5'd1);
			best_q <= '0;
			bestd_q <= part_q[0];
			if (req.req_type == REQ_DATA && 5'(req.dim_sel) < 5'(cfg.nd))
				vbuf_q[req.dim_sel[DIM_W-1:0]] <= req.coord;
		end
		if (state_q == ST_DIST && phase_q && ci_q == '0) bestd_q <= pnew;
		if (state_q == ST_PICK && ci_q != '0 && part_q[ci_q[CL_W-1:0]] < bestd_q) begin
			bestd_q <= part_q[ci_q[CL_W-1:0]];
			best_q <= ci_q[CL_W-1:0];
		end
		if (state_q == ST_OUT) begin
			if (rtype_q == REQ_DATA) begin
				res_kind_q <= RES_MEMBER;
				res_cl_q <= 4'(best_q);
				res_dist_q <= bestd_q[PART_W-1] ? {DIST_W{1'b1}} : bestd_q[DIST_W-1:0];
				res_sum_q <= '0;
				res_cnt_q <= '0;
			end else begin
				res_kind_q <= RES_READ;
				res_cl_q <= 4'(csel_q);
				res_dist_q <= '0;
				res_sum_q <= sel_ok_q ? sum_rdata : '0;
				res_cnt_q <= sel_ok_q ? cnt_q[csel_q] : '0;
			end
		end
	end

	assign res.valid = res_v_q;
	assign res.result_kind = res_kind_q;
	assign res.assigned_cluster = res_cl_q;
	assign res.min_distance = res_dist_q;
	assign res.cluster_sum = res_sum_q;
	assign res.cluster_count = res_cnt_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready) else $error("item accepted while busy");
	a_out_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> res_v_q) else $error("result not presented");
	a_pick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUMRD) |-> (5'(best_q) < 5'(cfg.nk))) else $error("winner out of range");
endmodule

// File: src/kaa_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
module kaa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: sim/kaa_if_tb.sv
// Testbench types: packed result item compared by the scoreboard.
package kaa_tb_types;
	import kaa_pkg::*;
	typedef struct packed {
		logic result_kind;
		logic [3:0] assigned_cluster;
		logic [DIST_W-1:0] min_distance;
		logic [SUM_W-1:0] cluster_sum;
		logic [CNT_W-1:0] cluster_count;
	} assign_res_t;
endpackage

// File: sim/tb_kmeans_assign_accumulate.sv
// Testbench: random and directed k-means requests checked against a scoreboard predictor.
module tb_kmeans_assign_accumulate;
	import kaa_pkg::*;
	import kaa_tb_types::*;

	// Predicts results of each accepted item and compares the block's results in order.
	class kmeans_scoreboard;
		logic [4:0] n_clusters_reg, n_dims_reg;
		logic signed [15:0] centroid[256];
		logic [36:0] partial[16];
		logic signed [15:0] vec_buf[16];
		logic signed [47:0] sums[256];
		logic [31:0] counts[16];
		assign_res_t pending_results[$];
		int mismatches;

		function void reset_state();
			n_clusters_reg = 2;
			n_dims_reg = 2;
			foreach (centroid[i]) centroid[i] = 0;
			foreach (sums[i]) sums[i] = 0;
			foreach (partial[i]) partial[i] = 0;
			foreach (vec_buf[i]) vec_buf[i] = 0;
			foreach (counts[i]) counts[i] = 0;
			pending_results.delete();
			mismatches = 0;
		endfunction

		function void set_reg(bit idx, logic [4:0] v);
			if (idx == CFG_CLUSTERS) n_clusters_reg = v;
			else n_dims_reg = v;
		endfunction

		function void note_item(req_t rq, logic [3:0] cs, logic [3:0] ds,
			logic signed [15:0] cv);
			int nk, nd, best;
			longint diff, s, ssum;
			logic [36:0] bestd;
			assign_res_t r;
			nk = (n_clusters_reg == 0) ? 1 : (n_clusters_reg > 16 ? 16 : n_clusters_reg);
			nd = (n_dims_reg == 0) ? 1 : (n_dims_reg > 16 ? 16 : n_dims_reg);
			r = '0;
			case (rq)
				REQ_LOAD: begin
					centroid[{cs, ds}] = cv;
				end
				REQ_CLEAR: begin
					foreach (sums[i]) sums[i] = 0;
					foreach (counts[i]) counts[i] = 0;
				end
				REQ_READ: begin
					r.result_kind = RES_READ;
					r.assigned_cluster = cs;
					r.cluster_sum = sums[{cs, ds}];
					r.cluster_count = counts[cs];
					pending_results.push_back(r);
				end
				default: begin
					if (ds < nd) begin
						vec_buf[ds] = cv;
						for (int c = 0; c < nk; c++) begin
							diff = longint'(cv) - longint'(centroid[{c[3:0], ds}]);
							s = diff * diff;
							if (s + longint'(partial[c]) > 64'h1F_FFFF_FFFF)
								partial[c] = '1;
							else
								partial[c] = partial[c] + s;
						end
						if (ds == nd - 1) begin
							best = 0;
							bestd = partial[0];
							for (int c = 1; c < nk; c++)
								if (partial[c] < bestd) begin
									bestd = partial[c];
									best = c;
								end
							if (counts[best] != '1) counts[best]++;
							for (int d = 0; d < nd; d++) begin
								ssum = longint'(sums[{best[3:0], d[3:0]}]) + longint'(vec_buf[d]);
								if (ssum > 64'sh7FFF_FFFF_FFFF) ssum = 64'sh7FFF_FFFF_FFFF;
								if (ssum < -64'sh8000_0000_0000) ssum = -64'sh8000_0000_0000;
								sums[{best[3:0], d[3:0]}] = ssum[47:0];
							end
							foreach (partial[i]) partial[i] = 0;
							r.result_kind = RES_MEMBER;
							r.assigned_cluster = best[3:0];
							r.min_distance = bestd[36] ? '1 : bestd[35:0];
							pending_results.push_back(r);
						end
					end
				end
			endcase
		endfunction

		function void check_result(assign_res_t got);
			assign_res_t want;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: kind %0d/%0d cl %0d/%0d dist %0d/%0d sum %0d/%0d cnt %0d/%0d",
						want.result_kind, got.result_kind, want.assigned_cluster,
						got.assigned_cluster, want.min_distance, got.min_distance,
						$signed(want.cluster_sum), $signed(got.cluster_sum),
						want.cluster_count, got.cluster_count);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	kaa_req_if req();
	kaa_res_if res();
	kmeans_scoreboard sb;
	int stall_pct, send_idle_pct, hold_off, quiet_cycles;
	logic [4:0] cur_k, cur_d;

	kmeans_assign_accumulate dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .res(res.source)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Record accepted items and check results at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready)
				sb.note_item(req_t'(req.req_type), req.cluster_sel, req.dim_sel, req.coord);
			if (res.valid && res.ready)
				sb.check_result({res.result_kind, res.assigned_cluster, res.min_distance,
					res.cluster_sum, res.cluster_count});
		end
	end

	// Drive result ready with random stalls and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Count cycles with no accepted item or result and stop a stuck run.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(req_t rq, logic [3:0] cs, logic [3:0] ds, logic [15:0] cv);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= rq;
		req.cluster_sel <= cs;
		req.dim_sel <= ds;
		req.coord <= cv;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic go_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	task automatic write_reg(bit idx, logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, v);
		if (idx == CFG_CLUSTERS) cur_k = v; else cur_d = v;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int eff(logic [4:0] v);
		return (v == 0) ? 1 : (v > 16 ? 16 : v);
	endfunction

	// Load all active centroids, fill the vector buffer, then send vectors with some noise.
	task automatic run_phase(int n_items);
		int sent, nk, nd;
		nk = eff(cur_k);
		nd = eff(cur_d);
		for (int c = 0; c < nk; c++)
			for (int d = 0; d < nd; d++)
				send_item(REQ_LOAD, c[3:0], d[3:0], rand_coord());
		for (int d = 0; d < nd; d++)
			send_item(REQ_DATA, 4'($urandom), d[3:0], rand_coord());
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(19))
				0: send_item(REQ_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom));
				1, 2: send_item(REQ_READ, 4'($urandom), 4'($urandom), 16'($urandom));
				3: send_item(REQ_LOAD, 4'($urandom_range(nk - 1)), 4'($urandom_range(nd - 1)),
					rand_coord());
				4: send_item(REQ_DATA, 4'($urandom_range(nd - 1)), 4'($urandom_range(nd - 1)),
					rand_coord());
				default: begin
					for (int d = 0; d < nd; d++) begin
						send_item(REQ_DATA, 4'($urandom), d[3:0], rand_coord());
						sent++;
					end
				end
			endcase
			sent++;
		end
		go_idle();
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.req_type = REQ_LOAD;
		req.cluster_sel = '0;
		req.dim_sel = '0;
		req.coord = '0;
		stall_pct = 22;
		send_idle_pct = 22;
		hold_off = 0;
		quiet_cycles = 0;
		cur_k = 2;
		cur_d = 2;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (300) @(posedge clk);

		// Directed: extremes, ties, ignored coordinate, reads and clear.
		send_item(REQ_LOAD, 0, 0, 16'h8000);
		send_item(REQ_LOAD, 0, 1, 16'h8000);
		send_item(REQ_LOAD, 1, 0, 16'h8000);
		send_item(REQ_LOAD, 1, 1, 16'h8000);
		send_item(REQ_DATA, 0, 0, 16'h7FFF);
		send_item(REQ_DATA, 0, 1, 16'h7FFF);
		send_item(REQ_DATA, 0, 5, 16'h1234);
		send_item(REQ_READ, 0, 0, 0);
		send_item(REQ_READ, 0, 1, 0);
		send_item(REQ_READ, 1, 0, 0);
		send_item(REQ_LOAD, 1, 0, 16'h0005);
		send_item(REQ_DATA, 0, 0, 16'h0004);
		send_item(REQ_DATA, 0, 0, 16'h0004);
		send_item(REQ_DATA, 0, 1, 16'h8000);
		send_item(REQ_READ, 15, 15, 0);
		send_item(REQ_CLEAR, 0, 0, 0);
		send_item(REQ_READ, 0, 0, 0);
		go_idle();

		// Extremes of the registers, including out-of-range values.
		write_reg(CFG_CLUSTERS, 0); write_reg(CFG_DIMS, 0); run_phase(60);
		write_reg(CFG_CLUSTERS, 31); write_reg(CFG_DIMS, 31); run_phase(120);
		write_reg(CFG_CLUSTERS, 16); write_reg(CFG_DIMS, 1); run_phase(200);

		// Long receiver hold-off while the sender keeps offering items.
		send_idle_pct = 0;
		hold_off = 400;
		write_reg(CFG_CLUSTERS, 3); write_reg(CFG_DIMS, 2); run_phase(150);
		send_idle_pct = 22;

		for (int p = 0; p < 8; p++) begin
			if (p == 4) begin
				stall_pct = 0;
				send_idle_pct = 0;
			end else begin
				stall_pct = 22;
				send_idle_pct = 22;
			end
			write_reg(CFG_CLUSTERS, 5'($urandom_range(16, 1)));
			write_reg(CFG_DIMS, 5'($urandom_range(6, 1)));
			run_phase(150);
		end

		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: filelist.f
src/kaa_pkg.sv
src/kaa_if.sv
src/kaa_ram.sv
src/kmeans_assign_accumulate.sv
sim/kaa_if_tb.sv
sim/tb_kmeans_assign_accumulate.sv
